FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while in reset.
`define DLQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dlq_pkg.sv
package dlq_pkg;

  localparam int IdW    = 3;
  localparam int NumIds = 8;
  localparam int TickW  = 48;
  localparam int DurW   = 32;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_RUNNING = 2'd1;
  localparam logic [1:0] RC_BADTIME = 2'd2;
  localparam logic [1:0] RC_FULL    = 2'd3;

  localparam logic [1:0] TS_IDLE = 2'd0;
  localparam logic [1:0] TS_RUN  = 2'd1;
  localparam logic [1:0] TS_DONE = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IdW-1:0]   timer_id;
    logic [TickW-1:0] now_tick;
    logic             is_periodic;
    logic             is_absolute;
    logic [TickW-1:0] start_time;
    logic [DurW-1:0]  duration;
  } dlq_in_t;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [IdW-1:0]   event_timer;
    logic [1:0]       result_code;
    logic [TickW-1:0] next_expiry_tick;
    logic             last_result;
  } dlq_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_TEND, S_ABS, S_MODW, S_CHK,
    S_LSTEP, S_LFIN, S_USTEP, S_UFIN, S_ANS
  } dlq_state_t;

endpackage

FILE: hw/rtl/dlq_mod.sv
`include "assert_macros.svh"

// Restoring remainder unit, one dividend bit per cycle.
module dlq_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [dlq_pkg::TickW-1:0] dividend,
  input  logic [dlq_pkg::DurW-1:0]  divisor,
  output logic                      done,
  output logic [dlq_pkg::DurW-1:0]  rem
);
  import dlq_pkg::*;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [TickW-1:0] dvd_r, dvd_nxt;
  logic [DurW-1:0]  div_r, div_nxt;
  logic [DurW-1:0]  rem_r, rem_nxt;
  logic [DurW:0]    sh;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    sh       = {rem_r, dvd_r[TickW-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = 6'(TickW);
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      if (sh >= {1'b0, div_r}) begin
        sh = sh - {1'b0, div_r};
      end
      rem_nxt = sh[DurW-1:0];
      dvd_nxt = {dvd_r[TickW-2:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  `DLQ_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "remainder done held")
  `DLQ_ASSERT(a_run_cnt, !run_r || cnt_r != 6'd0, "remainder unit runs with zero count")

endmodule

FILE: hw/rtl/delta_list_timer_queue.sv
`include "assert_macros.svh"

// Delta-list timer queue. An item is taken when start is high and busy low.
// Each result is shown on out_item for one cycle with out_valid high; the
// receiver cannot stall and must take each result in the cycle it is shown.
// The last result of an item shows in the first cycle after busy falls, so a
// new item may be taken in that cycle. A relative start walks the linked list
// to its sorted place; an absolute start first passes S_ABS, and a past expiry
// of a periodic timer also waits on the bit-serial remainder unit. A start
// refused for its id or a running timer goes straight to the answer. A stop of
// a running timer walks past each entry ahead of it to unlink it, any other
// stop goes straight to the answer. A tick takes up to MAX_EXPIRIES expiries,
// one per pass, and reinserts each periodic one by a sorted walk of the list.
module delta_list_timer_queue #(
  parameter int NUM_TIMERS   = 8,
  parameter int MAX_EXPIRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dlq_pkg::dlq_in_t  in_item,
  output logic              out_valid,
  output dlq_pkg::dlq_out_t out_item
);
  import dlq_pkg::*;

  dlq_state_t       state_r, state_nxt;
  dlq_in_t          in_r, in_nxt;
  logic [DurW-1:0]  dap_r [NumIds], dap_nxt [NumIds];
  logic [DurW-1:0]  rel_r [NumIds], rel_nxt [NumIds];
  logic [IdW-1:0]   lnk_r [NumIds], lnk_nxt [NumIds];
  logic [1:0]       stat_r [NumIds], stat_nxt [NumIds];
  logic [NumIds-1:0] per_r, per_nxt;
  logic [IdW-1:0]   head_r, head_nxt;
  logic [3:0]       count_r, count_nxt;
  logic [TickW-1:0] last_r, last_nxt;
  logic [TickW-1:0] pend_r, pend_nxt;
  logic [TickW-1:0] d_r, d_nxt;
  logic [6:0]       n_r, n_nxt;
  logic [IdW-1:0]   cur_r, cur_nxt;
  logic [IdW-1:0]   prev_r, prev_nxt;
  logic             hasp_r, hasp_nxt;
  logic             found_r, found_nxt;
  logic [3:0]       wn_r, wn_nxt;
  logic [DurW-1:0]  v_r, v_nxt;
  logic [IdW-1:0]   lid_r, lid_nxt;
  logic [TickW:0]   cntv_r, cntv_nxt;
  logic [DurW-1:0]  period_r, period_nxt;
  logic [1:0]       code_r, code_nxt;
  logic [TickW-1:0] nexp_r, nexp_nxt;
  logic             bufv_r, bufv_nxt;
  dlq_out_t         buf_r, buf_nxt;
  logic             outv_r, outv_nxt;
  dlq_out_t         out_r, out_nxt;

  logic             mod_go;
  logic             mod_done;
  logic [DurW-1:0]  mod_rem;
  logic [TickW-1:0] mod_dvd;

  logic [TickW:0]   sum49;
  logic [DurW:0]    sum33;
  logic [IdW-1:0]   h;
  logic             id_ok;
  logic             full;

  assign id_ok = 7'(in_r.timer_id) < 7'(NUM_TIMERS);
  assign full  = 7'(count_r) >= 7'(NUM_TIMERS);
  assign busy  = state_r != S_IDLE;

  dlq_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (mod_dvd),
    .divisor  (period_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    in_nxt     = in_r;
    dap_nxt    = dap_r;
    rel_nxt    = rel_r;
    lnk_nxt    = lnk_r;
    stat_nxt   = stat_r;
    per_nxt    = per_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    d_nxt      = d_r;
    n_nxt      = n_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    hasp_nxt   = hasp_r;
    found_nxt  = found_r;
    wn_nxt     = wn_r;
    v_nxt      = v_r;
    lid_nxt    = lid_r;
    cntv_nxt   = cntv_r;
    period_nxt = period_r;
    code_nxt   = code_r;
    nexp_nxt   = nexp_r;
    bufv_nxt   = bufv_r;
    buf_nxt    = buf_r;
    outv_nxt   = 1'b0;
    out_nxt    = out_r;
    mod_go     = 1'b0;
    mod_dvd    = '0;
    sum49      = '0;
    sum33      = '0;
    h          = head_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt     = in_item;
          code_nxt   = RC_OK;
          nexp_nxt   = '0;
          cur_nxt    = head_r;
          wn_nxt     = '0;
          hasp_nxt   = 1'b0;
          period_nxt = (in_item.is_periodic && in_item.duration != '0) ?
                       in_item.duration : '0;
          case (in_item.opcode)
            OP_TICK: begin
              sum49    = {1'b0, pend_r} + {1'b0, in_item.now_tick - last_r};
              d_nxt    = sum49[TickW] ? '1 : sum49[TickW-1:0];
              last_nxt = in_item.now_tick;
              n_nxt    = '0;
              bufv_nxt = 1'b0;
              state_nxt = S_TICK;
            end
            OP_START: begin
              if (7'(in_item.timer_id) >= 7'(NUM_TIMERS)) begin
                code_nxt  = RC_BADTIME;
                state_nxt = S_ANS;
              end else if (stat_r[in_item.timer_id] == TS_RUN) begin
                code_nxt  = RC_RUNNING;
                state_nxt = S_ANS;
              end else if (in_item.is_absolute) begin
                state_nxt = S_ABS;
              end else begin
                cntv_nxt  = (TickW+1)'(in_item.duration);
                state_nxt = S_CHK;
              end
            end
            OP_STOP: begin
              if (7'(in_item.timer_id) < 7'(NUM_TIMERS)) begin
                stat_nxt[in_item.timer_id] = TS_IDLE;
                state_nxt = (stat_r[in_item.timer_id] == TS_RUN) ? S_USTEP : S_ANS;
              end else begin
                state_nxt = S_ANS;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ABS: begin
        sum49 = {1'b0, in_r.start_time} + (TickW+1)'(in_r.duration);
        if (sum49 <= {1'b0, in_r.now_tick}) begin
          if (period_r == '0) begin
            code_nxt  = RC_BADTIME;
            state_nxt = S_ANS;
          end else begin
            mod_go    = 1'b1;
            mod_dvd   = in_r.now_tick - sum49[TickW-1:0];
            state_nxt = S_MODW;
          end
        end else begin
          cntv_nxt  = sum49 - {1'b0, in_r.now_tick};
          state_nxt = S_CHK;
        end
      end

      S_MODW: begin
        if (mod_done) begin
          cntv_nxt  = (TickW+1)'(period_r - mod_rem);
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        if (cntv_r == '0 || cntv_r[TickW:DurW] != '0) begin
          code_nxt  = RC_BADTIME;
          state_nxt = S_ANS;
        end else if (full) begin
          code_nxt  = RC_FULL;
          state_nxt = S_ANS;
        end else begin
          rel_nxt[in_r.timer_id] = period_r;
          per_nxt[in_r.timer_id] = period_r != '0;
          lid_nxt   = in_r.timer_id;
          v_nxt     = cntv_r[DurW-1:0];
          nexp_nxt  = in_r.now_tick + cntv_r[TickW-1:0];
          state_nxt = S_LSTEP;
        end
      end

      // sorted insert: walk while the entry's delay fits in what is left
      S_LSTEP: begin
        if (wn_r < count_r) begin
          if (dap_r[cur_r] > v_r) begin
            found_nxt = 1'b1;
            state_nxt = S_LFIN;
          end else begin
            v_nxt    = v_r - dap_r[cur_r];
            prev_nxt = cur_r;
            hasp_nxt = 1'b1;
            cur_nxt  = lnk_r[cur_r];
            wn_nxt   = wn_r + 4'd1;
          end
        end else begin
          found_nxt = 1'b0;
          state_nxt = S_LFIN;
        end
      end

      S_LFIN: begin
        dap_nxt[lid_r] = v_r;
        if (found_r) begin
          dap_nxt[cur_r] = dap_r[cur_r] - v_r;
          lnk_nxt[lid_r] = cur_r;
        end else begin
          lnk_nxt[lid_r] = '0;
        end
        if (hasp_r) begin
          lnk_nxt[prev_r] = lid_r;
        end else begin
          head_nxt = lid_r;
        end
        count_nxt       = count_r + 4'd1;
        stat_nxt[lid_r] = TS_RUN;
        state_nxt = (in_r.opcode == OP_TICK) ? S_TICK : S_ANS;
      end

      S_USTEP: begin
        if (wn_r < count_r) begin
          if (cur_r == in_r.timer_id) begin
            state_nxt = S_UFIN;
          end else begin
            prev_nxt = cur_r;
            hasp_nxt = 1'b1;
            cur_nxt  = lnk_r[cur_r];
            wn_nxt   = wn_r + 4'd1;
          end
        end else begin
          state_nxt = S_ANS;
        end
      end

      S_UFIN: begin
        if (wn_r + 4'd1 < count_r) begin
          sum33 = {1'b0, dap_r[lnk_r[cur_r]]} + {1'b0, dap_r[cur_r]};
          dap_nxt[lnk_r[cur_r]] = sum33[DurW] ? '1 : sum33[DurW-1:0];
        end
        if (hasp_r) begin
          lnk_nxt[prev_r] = lnk_r[cur_r];
        end else begin
          head_nxt = lnk_r[cur_r];
        end
        count_nxt = count_r - 4'd1;
        state_nxt = S_ANS;
      end

      // one expiry per pass; the previous one goes out once another follows, the last in S_TEND
      S_TICK: begin
        if (count_r != '0 && n_r < 7'(MAX_EXPIRIES) && (TickW)'(dap_r[h]) <= d_r) begin
          d_nxt     = d_r - (TickW)'(dap_r[h]);
          head_nxt  = lnk_r[h];
          count_nxt = count_r - 4'd1;
          n_nxt     = n_r + 7'd1;
          if (bufv_r) begin
            outv_nxt = 1'b1;
            out_nxt  = buf_r;
          end
          bufv_nxt               = 1'b1;
          buf_nxt.event_kind     = KIND_EXPIRED;
          buf_nxt.event_timer    = h;
          buf_nxt.result_code    = RC_OK;
          buf_nxt.last_result    = 1'b0;
          buf_nxt.next_expiry_tick = '0;
          if (per_r[h]) begin
            buf_nxt.next_expiry_tick = in_r.now_tick + (TickW)'(rel_r[h]);
            lid_nxt   = h;
            v_nxt     = rel_r[h];
            cur_nxt   = lnk_r[h];
            wn_nxt    = '0;
            hasp_nxt  = 1'b0;
            state_nxt = S_LSTEP;
          end else begin
            stat_nxt[h] = TS_DONE;
          end
        end else begin
          state_nxt = S_TEND;
        end
      end

      S_TEND: begin
        if (count_r == '0) begin
          pend_nxt = '0;
        end else if ((TickW)'(dap_r[head_r]) <= d_r) begin
          pend_nxt = d_r;
        end else begin
          dap_nxt[head_r] = dap_r[head_r] - d_r[DurW-1:0];
          pend_nxt        = '0;
        end
        if (bufv_r) begin
          outv_nxt            = 1'b1;
          out_nxt             = buf_r;
          out_nxt.last_result = 1'b1;
        end
        bufv_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end

      S_ANS: begin
        outv_nxt                 = 1'b1;
        out_nxt.event_kind       = (in_r.opcode == OP_STOP) ? KIND_STOP : KIND_START;
        out_nxt.event_timer      = in_r.timer_id;
        out_nxt.result_code      = code_r;
        out_nxt.next_expiry_tick = nexp_r;
        out_nxt.last_result      = 1'b1;
        state_nxt                = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NumIds; i++) begin
        stat_r[i] <= TS_IDLE;
      end
      per_r   <= '0;
      head_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
      pend_r  <= '0;
      bufv_r  <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
      per_r   <= per_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      pend_r  <= pend_nxt;
      bufv_r  <= bufv_nxt;
      outv_r  <= outv_nxt;
    end
    in_r     <= in_nxt;
    dap_r    <= dap_nxt;
    rel_r    <= rel_nxt;
    lnk_r    <= lnk_nxt;
    d_r      <= d_nxt;
    n_r      <= n_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    hasp_r   <= hasp_nxt;
    found_r  <= found_nxt;
    wn_r     <= wn_nxt;
    v_r      <= v_nxt;
    lid_r    <= lid_nxt;
    cntv_r   <= cntv_nxt;
    period_r <= period_nxt;
    code_r   <= code_nxt;
    nexp_r   <= nexp_nxt;
    buf_r    <= buf_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = outv_r;
  assign out_item  = out_r;

  `DLQ_ASSERT(a_count_max, count_r <= 4'(NumIds), "list count above timer count")
  `DLQ_ASSERT_NEXT(a_accept_busy, start && !busy && in_item.opcode != OP_IGNORE, busy, "accepted item did not raise busy")
  `DLQ_ASSERT(a_out_from_busy, !outv_r || $past(state_r != S_IDLE), "result while idle")
  `DLQ_ASSERT(a_stop_idle_id, !(state_r == S_USTEP) || id_ok, "walk with bad id")

endmodule
